// ----- rtl/csr_sma_pkg.sv -----
`default_nettype none

package csr_sma_pkg;

    // Default sizing
    localparam int CSR_MAX_ROWS      = 1024;
    localparam int CSR_MAX_ENTRIES   = 4096;
    localparam int CSR_MAX_ROW_SLOTS = 64;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int IDX_W    = 16;
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = 12;
    localparam int STAT_W   = 3;
    localparam int NROWS_W  = 11;
    localparam int NCOLS_W  = 16;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 48;

    // Register reset values
    localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 11'd1024;
    localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 16'd1024;
    localparam logic               ALLOW_RST    = 1'b1;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_SETUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_ALLOW    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RS_END,
        S_RS_WAIT,
        S_SCAN,
        S_VRD,
        S_VUSE,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/csr_sparse_matrix_assembly.sv -----
`default_nettype none

// Compressed-row sparse matrix store. Rows are defined one after another by setup
// transactions (tuser = 0) giving each row's slot count; the row's first slot holds
// the diagonal. Set, add and read transactions locate a column by scanning the row's
// slots in the column memory, one slot per cycle, and allocate the first empty slot
// for a new column when allowed. Each transaction yields exactly one result. A setup
// initializes the row's slots in the column and value memories; a rejected setup or
// an out-of-range or undefined-row access goes straight to the result, and a diagonal
// access skips the scan. A new result waits while the previous one is stalled on
// m_tready. Memories have no reset pass;
// only slots of defined rows are ever read. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module csr_sparse_matrix_assembly
    import csr_sma_pkg::*;
#(
    parameter int MAX_ROWS      = CSR_MAX_ROWS,
    parameter int MAX_ENTRIES   = CSR_MAX_ENTRIES,
    parameter int MAX_ROW_SLOTS = CSR_MAX_ROW_SLOTS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // row[15:0], col[31:16], slot_count[38:32], value[70:39], zero pad
    input  wire logic [IN_W-1:0]     s_tdata,
    // req_type[1:0]
    input  wire logic [REQ_W-1:0]    s_tuser,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // read_value[31:0], slot_index[43:32], status[46:44], zero pad
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [CFG_D_W-1:0]  cfg_data
);

    localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PTR_W    = $clog2(MAX_ENTRIES + 1);
    localparam int RS_AW    = $clog2(MAX_ROWS + 1);
    localparam int SC_W     = $clog2(MAX_ROW_SLOTS + 1);

    // Input fields
    logic [REQ_W-1:0]        in_req;
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic [CNT_W-1:0]        in_cnt;
    logic signed [VAL_W-1:0] in_val;

    assign in_req = s_tuser;
    assign in_row = s_tdata[15:0];
    assign in_col = s_tdata[31:16];
    assign in_cnt = s_tdata[38:32];
    assign in_val = s_tdata[70:39];

    // Control and payload registers
    state_t                  state_reg, state_next;
    logic [NROWS_W-1:0]      num_rows_reg, num_rows_next;
    logic [NCOLS_W-1:0]      num_cols_reg, num_cols_next;
    logic                    allow_reg, allow_next;
    logic [RS_AW-1:0]        rows_def_reg, rows_def_next;
    logic [PTR_W-1:0]        alloc_reg, alloc_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [RS_AW-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        col_reg, col_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [PTR_W-1:0]        base_reg, base_next;
    logic [PTR_W-1:0]        end_reg, end_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [ENTRY_AW-1:0]     pend_addr_reg, pend_addr_next;
    logic                    empty_found_reg, empty_found_next;
    logic [ENTRY_AW-1:0]     empty_slot_reg, empty_slot_next;
    logic [ENTRY_AW-1:0]     slot_reg, slot_next;
    logic                    new_entry_reg, new_entry_next;
    logic [IDX_W-1:0]        tag_reg, tag_next;
    logic [VAL_W-1:0]        res_value_reg, res_value_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]        out_value_reg, out_value_next;
    logic [SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;

    // Row start memory
    logic [PTR_W-1:0]    rs_mem [MAX_ROWS + 1];
    logic                rs_we, rs_re;
    logic [RS_AW-1:0]    rs_waddr, rs_raddr;
    logic [PTR_W-1:0]    rs_wdata, rs_rdata_reg, rs_val;
    logic                rs_zero_reg;

    // Slot column memory: bit 16 marks a used slot
    logic [IDX_W:0]      col_mem [MAX_ENTRIES];
    logic                col_we, col_re;
    logic [ENTRY_AW-1:0] col_waddr, col_raddr;
    logic [IDX_W:0]      col_wdata, col_rdata_reg;

    // Slot value memory
    logic [VAL_W-1:0]    vm_mem [MAX_ENTRIES];
    logic                vm_we, vm_re;
    logic [ENTRY_AW-1:0] vm_waddr, vm_raddr;
    logic [VAL_W-1:0]    vm_wdata, vm_rdata_reg;

    // Helpers
    logic                    accept;
    logic [31:0]             rows_lim;
    logic [SC_W-1:0]         n_eff;
    logic                    setup_fail;
    logic                    hit;
    logic signed [VAL_W-1:0] old_val;
    logic signed [VAL_W:0]   sum;
    logic [VAL_W-1:0]        sat_val;

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        if (rs_re)
        begin
            rs_rdata_reg <= rs_mem[rs_raddr];
            rs_zero_reg  <= (rs_raddr == '0);
        end
    end

    // entry 0 is never written and reads as zero
    assign rs_val = rs_zero_reg ? '0 : rs_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_rdata_reg <= col_mem[col_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vm_mem[vm_waddr] <= vm_wdata;
        end
        if (vm_re)
        begin
            vm_rdata_reg <= vm_mem[vm_raddr];
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_status_reg, out_slot_reg, out_value_reg};

    assign rows_lim = (32'(num_rows_reg) < 32'(MAX_ROWS)) ? 32'(num_rows_reg)
                                                         : 32'(MAX_ROWS);

    always_comb
    begin
        if (in_cnt == '0)
        begin
            n_eff = SC_W'(1);
        end
        else if (32'(in_cnt) > 32'(MAX_ROW_SLOTS))
        begin
            n_eff = SC_W'(MAX_ROW_SLOTS);
        end
        else
        begin
            n_eff = SC_W'(in_cnt);
        end
    end

    assign setup_fail = (32'(rows_def_reg) >= rows_lim)
                     || (32'(alloc_reg) + 32'(n_eff) > 32'(MAX_ENTRIES));

    assign hit = pend_valid_reg && (col_rdata_reg == {1'b1, col_reg});

    assign old_val = new_entry_reg ? '0 : $signed(vm_rdata_reg);
    assign sum     = {old_val[VAL_W-1], old_val} + {val_reg[VAL_W-1], val_reg};
    assign sat_val = (sum[VAL_W] != sum[VAL_W-1])
                   ? (sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}})
                   : sum[VAL_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        num_rows_next    = num_rows_reg;
        num_cols_next    = num_cols_reg;
        allow_next       = allow_reg;
        rows_def_next    = rows_def_reg;
        alloc_next       = alloc_reg;
        req_next         = req_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        val_next         = val_reg;
        base_next        = base_reg;
        end_next         = end_reg;
        ptr_next         = ptr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        empty_found_next = empty_found_reg;
        empty_slot_next  = empty_slot_reg;
        slot_next        = slot_reg;
        new_entry_next   = new_entry_reg;
        tag_next         = tag_reg;
        res_value_next   = res_value_reg;
        res_slot_next    = res_slot_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_value_next   = out_value_reg;
        out_slot_next    = out_slot_reg;
        out_status_next  = out_status_reg;

        rs_we     = 1'b0;
        rs_waddr  = '0;
        rs_wdata  = '0;
        rs_re     = 1'b0;
        rs_raddr  = '0;
        col_we    = 1'b0;
        col_waddr = '0;
        col_wdata = '0;
        col_re    = 1'b0;
        col_raddr = '0;
        vm_we     = 1'b0;
        vm_waddr  = '0;
        vm_wdata  = '0;
        vm_re     = 1'b0;
        vm_raddr  = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_next = cfg_data[NROWS_W-1:0];
                CFG_NUM_COLS: num_cols_next = cfg_data[NCOLS_W-1:0];
                CFG_ALLOW:    allow_next    = cfg_data[0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_slot_next   = '0;
                    if (in_req == REQ_SETUP)
                    begin
                        if (setup_fail)
                        begin
                            res_status_next = ST_OVERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rs_we           = 1'b1;
                            rs_waddr        = rows_def_reg + RS_AW'(1);
                            rs_wdata        = alloc_reg + PTR_W'(n_eff);
                            alloc_next      = alloc_reg + PTR_W'(n_eff);
                            rows_def_next   = rows_def_reg + RS_AW'(1);
                            tag_next        = IDX_W'(rows_def_reg);
                            base_next       = alloc_reg;
                            ptr_next        = alloc_reg;
                            end_next        = alloc_reg + PTR_W'(n_eff);
                            res_slot_next   = SLOT_W'(alloc_reg);
                            res_status_next = ST_OK;
                            state_next      = S_SETUP;
                        end
                    end
                    else if ((32'(in_row) >= rows_lim) || (in_col >= num_cols_reg))
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_RESP;
                    end
                    else if (32'(in_row) >= 32'(rows_def_reg))
                    begin
                        res_status_next = ST_NOTALLOC;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        req_next   = in_req;
                        row_next   = RS_AW'(in_row);
                        col_next   = in_col;
                        val_next   = in_val;
                        rs_re      = 1'b1;
                        rs_raddr   = RS_AW'(in_row);
                        state_next = S_RS_END;
                    end
                end
            end

            S_SETUP:
            begin
                // diagonal goes to the first slot, the rest are marked empty
                col_we    = 1'b1;
                col_waddr = ptr_reg[ENTRY_AW-1:0];
                col_wdata = (ptr_reg == base_reg) ? {1'b1, tag_reg} : '0;
                vm_we     = 1'b1;
                vm_waddr  = ptr_reg[ENTRY_AW-1:0];
                vm_wdata  = '0;
                ptr_next  = ptr_reg + PTR_W'(1);
                if (ptr_reg + PTR_W'(1) == end_reg)
                begin
                    state_next = S_RESP;
                end
            end

            S_RS_END:
            begin
                base_next        = rs_val;
                ptr_next         = rs_val + PTR_W'(1);
                rs_re            = 1'b1;
                rs_raddr         = row_reg + RS_AW'(1);
                pend_valid_next  = 1'b0;
                empty_found_next = 1'b0;
                new_entry_next   = 1'b0;
                state_next       = S_RS_WAIT;
            end

            S_RS_WAIT:
            begin
                end_next = rs_val;
                if (32'(row_reg) == 32'(col_reg))
                begin
                    slot_next  = base_reg[ENTRY_AW-1:0];
                    state_next = S_VRD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, checked the cycle after
                if (hit)
                begin
                    slot_next       = pend_addr_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_VRD;
                end
                else
                begin
                    if (pend_valid_reg && !col_rdata_reg[IDX_W] && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_slot_next  = pend_addr_reg;
                    end
                    if (ptr_reg < end_reg)
                    begin
                        col_re          = 1'b1;
                        col_raddr       = ptr_reg[ENTRY_AW-1:0];
                        pend_valid_next = 1'b1;
                        pend_addr_next  = ptr_reg[ENTRY_AW-1:0];
                        ptr_next        = ptr_reg + PTR_W'(1);
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        if (!pend_valid_reg)
                        begin
                            res_value_next = '0;
                            res_slot_next  = '0;
                            if (req_reg == REQ_READ)
                            begin
                                res_status_next = ST_ABSENT;
                                state_next      = S_RESP;
                            end
                            else if (allow_reg && empty_found_reg)
                            begin
                                col_we         = 1'b1;
                                col_waddr      = empty_slot_reg;
                                col_wdata      = {1'b1, col_reg};
                                slot_next      = empty_slot_reg;
                                new_entry_next = 1'b1;
                                state_next     = S_VRD;
                            end
                            else
                            begin
                                res_status_next = ST_NOTALLOC;
                                state_next      = S_RESP;
                            end
                        end
                    end
                end
            end

            S_VRD:
            begin
                vm_re      = 1'b1;
                vm_raddr   = slot_reg;
                state_next = S_VUSE;
            end

            S_VUSE:
            begin
                res_value_next  = '0;
                res_slot_next   = SLOT_W'(slot_reg);
                res_status_next = ST_OK;
                case (req_reg)
                    REQ_SET:
                    begin
                        vm_we    = 1'b1;
                        vm_waddr = slot_reg;
                        vm_wdata = val_reg;
                    end
                    REQ_ADD:
                    begin
                        vm_we    = 1'b1;
                        vm_waddr = slot_reg;
                        vm_wdata = sat_val;
                    end
                    default:
                    begin
                        res_value_next = old_val;
                    end
                endcase
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_slot_next   = res_slot_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_rows_reg    <= NUM_ROWS_RST;
            num_cols_reg    <= NUM_COLS_RST;
            allow_reg       <= ALLOW_RST;
            rows_def_reg    <= '0;
            alloc_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            empty_found_reg <= 1'b0;
            new_entry_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_rows_reg    <= num_rows_next;
            num_cols_reg    <= num_cols_next;
            allow_reg       <= allow_next;
            rows_def_reg    <= rows_def_next;
            alloc_reg       <= alloc_next;
            pend_valid_reg  <= pend_valid_next;
            empty_found_reg <= empty_found_next;
            new_entry_reg   <= new_entry_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        base_reg       <= base_next;
        end_reg        <= end_next;
        ptr_reg        <= ptr_next;
        pend_addr_reg  <= pend_addr_next;
        empty_slot_reg <= empty_slot_next;
        slot_reg       <= slot_next;
        tag_reg        <= tag_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csr_sma_pkg::*;

    // cycles the block may still need after its last result (longest row scan plus margin)
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD    = 400;
    localparam int DIR_N        = 24;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [CNT_W-1:0]  cnt;
        logic [VAL_W-1:0]  val;
    } entry_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [SLOT_W-1:0] slot_index;
        logic [STAT_W-1:0] status;
    } entry_res_t;

    typedef struct packed {
        entry_req_t rq;
        logic       typed;
        entry_res_t res;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0]  cfg_data  = '0;

    csr_sparse_matrix_assembly dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the matrix store
    logic [NROWS_W-1:0] shadow_num_rows = NUM_ROWS_RST;
    logic [NCOLS_W-1:0] shadow_num_cols = NUM_COLS_RST;
    logic               shadow_allow    = ALLOW_RST;
    int unsigned        shadow_row_start [0:CSR_MAX_ROWS];
    logic [16:0]        shadow_slot_col  [0:CSR_MAX_ENTRIES-1];
    logic signed [31:0] shadow_slot_val  [0:CSR_MAX_ENTRIES-1];
    int unsigned        shadow_rows_defined = 0;

    entry_res_t pending_results [$];
    int         mismatches   = 0;
    int         burst_left   = 0;
    bit         hold_request = 1'b0;

    initial
    begin
        shadow_row_start[0] = 0;
        for (int i = 0; i < CSR_MAX_ENTRIES; i++)
        begin
            shadow_slot_col[i] = '0;
            shadow_slot_val[i] = '0;
        end
    end

    function automatic int unsigned rows_cap();
        return (shadow_num_rows < CSR_MAX_ROWS) ? shadow_num_rows : CSR_MAX_ROWS;
    endfunction

    function automatic entry_res_t predict_entry_result(input entry_req_t it);
        entry_res_t  res;
        int unsigned n, lim, base, stop, slot;
        longint      sum;
        res  = '0;
        lim  = rows_cap();
        slot = CSR_MAX_ENTRIES;
        if (it.req == REQ_SETUP)
        begin
            n = it.cnt;
            if (n < 1) n = 1;
            if (n > CSR_MAX_ROW_SLOTS) n = CSR_MAX_ROW_SLOTS;
            res.status = ST_OVERFLOW;
            if (shadow_rows_defined >= lim) return res;
            base = shadow_row_start[shadow_rows_defined];
            if (base + n > CSR_MAX_ENTRIES) return res;
            shadow_slot_col[base] = {1'b1, 16'(shadow_rows_defined)};
            shadow_slot_val[base] = '0;
            for (int unsigned k = base + 1; k < base + n; k++)
            begin
                shadow_slot_col[k] = '0;
                shadow_slot_val[k] = '0;
            end
            shadow_row_start[shadow_rows_defined + 1] = base + n;
            shadow_rows_defined++;
            res.status     = ST_OK;
            res.slot_index = SLOT_W'(base);
            return res;
        end
        if (it.row >= lim || it.col >= shadow_num_cols)
        begin
            res.status = ST_RANGE;
            return res;
        end
        res.status = ST_NOTALLOC;
        if (it.row >= shadow_rows_defined) return res;
        base = shadow_row_start[it.row];
        stop = shadow_row_start[it.row + 1];
        if (stop > CSR_MAX_ENTRIES) stop = CSR_MAX_ENTRIES;
        if (base >= CSR_MAX_ENTRIES) return res;
        if (it.row == it.col)
            slot = base;
        else
            for (int unsigned k = base + 1; k < stop; k++)
                if (slot == CSR_MAX_ENTRIES && shadow_slot_col[k] == {1'b1, it.col})
                    slot = k;
        if (slot >= CSR_MAX_ENTRIES)
        begin
            if (it.req == REQ_READ)
            begin
                res.status = ST_ABSENT;
                return res;
            end
            if (shadow_allow)
                for (int unsigned k = base + 1; k < stop; k++)
                    if (slot == CSR_MAX_ENTRIES && !shadow_slot_col[k][16])
                        slot = k;
            if (slot >= CSR_MAX_ENTRIES) return res;
            shadow_slot_col[slot] = {1'b1, it.col};
            shadow_slot_val[slot] = '0;
        end
        res.status     = ST_OK;
        res.slot_index = SLOT_W'(slot);
        if (it.req == REQ_SET)
            shadow_slot_val[slot] = $signed(it.val);
        else if (it.req == REQ_ADD)
        begin
            sum = longint'(shadow_slot_val[slot]) + longint'($signed(it.val));
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            shadow_slot_val[slot] = 32'(sum);
        end
        else
            res.read_value = shadow_slot_val[slot];
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // mostly accesses to rows that exist, on a small pool of columns per row
    function automatic entry_req_t gen_req(input int setup_pct);
        entry_req_t  it;
        int unsigned avail, lim, p, k;
        it.req = REQ_W'($urandom);
        it.row = IDX_W'($urandom);
        it.col = IDX_W'($urandom);
        it.cnt = CNT_W'($urandom);
        it.val = $urandom;
        lim    = rows_cap();
        avail  = (shadow_rows_defined < lim) ? shadow_rows_defined : lim;
        p      = $urandom_range(0, 99);
        if (p < 7) return it;
        if (p < 7 + setup_pct || avail == 0)
        begin
            it.req = REQ_SETUP;
            it.cnt = CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 6));
            return it;
        end
        case ($urandom_range(0, 2))
            0: it.req = REQ_SET;
            1: it.req = REQ_ADD;
            default: it.req = REQ_READ;
        endcase
        it.val = pick_value();
        if ($urandom_range(0, 15) == 0)
            it.row = IDX_W'(avail + $urandom_range(0, 3));
        else
            it.row = IDX_W'($urandom_range(0, avail - 1));
        if ($urandom_range(0, 15) != 0)
        begin
            k      = $urandom_range(0, 7);
            it.col = (k == 0) ? it.row : IDX_W'((it.row + k) % shadow_num_cols);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got_v, want_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        entry_res_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[43:32], m_tdata[46:44]};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(got), 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
        end
    end

    // receiver: stall pattern changes after each random span, one long hold on request
    initial
    begin
        int span, pct;
        span = 0;
        pct  = 100;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    span = $urandom_range(50, 300);
                    case ($urandom_range(0, 3))
                        0: pct = 100;
                        1: pct = 80;
                        2: pct = 40;
                        default: pct = 15;
                    endcase
                end
                span--;
                m_tready <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    task automatic offer_req(input entry_req_t it, input logic typed, input entry_res_t typed_res);
        entry_res_t r;
        int         gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  <= {1'b0, it.val, it.cnt, it.col, it.row};
        s_tuser  <= it.req;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = predict_entry_result(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    task automatic write_config(input logic [15:0] nr, input logic [15:0] nc, input logic al);
        logic [CFG_IX_W-1:0] idx [3];
        logic [CFG_D_W-1:0]  dat [3];
        idx = '{CFG_NUM_ROWS, CFG_NUM_COLS, CFG_ALLOW};
        dat = '{nr, nc, {15'd0, al}};
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx[i])
                CFG_NUM_ROWS: shadow_num_rows = dat[i][NROWS_W-1:0];
                CFG_NUM_COLS: shadow_num_cols = dat[i][NCOLS_W-1:0];
                CFG_ALLOW:    shadow_allow    = dat[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int setup_pct, input int hold_at);
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at) hold_request = 1'b1;
            offer_req(gen_req(setup_pct), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // rows set up here: row 0 one slot, row 1 64 slots from 1, row 2 three from 65,
    // row 3 64 from 68
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{'{REQ_READ,  16'd0,     16'd0,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_NOTALLOC}},
        '{'{REQ_SET,   16'hFFFF,  16'd0,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_RANGE}},
        '{'{REQ_READ,  16'd0,     16'd1024,  7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_RANGE}},
        '{'{REQ_SETUP, 16'd0,     16'd0,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_OK}},
        '{'{REQ_SETUP, 16'hFFFF,  16'hFFFF,  7'd127, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0,         12'd1,  ST_OK}},
        '{'{REQ_SETUP, 16'd0,     16'd0,     7'd3,   32'h0},         1'b1,
          '{32'h0,         12'd65, ST_OK}},
        '{'{REQ_SETUP, 16'd0,     16'd0,     7'd64,  32'h0},         1'b1,
          '{32'h0,         12'd68, ST_OK}},
        '{'{REQ_READ,  16'd0,     16'd0,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_OK}},
        '{'{REQ_SET,   16'd0,     16'd0,     7'd0,   32'h7FFF_FFFF}, 1'b1,
          '{32'h0,         12'd0,  ST_OK}},
        '{'{REQ_ADD,   16'd0,     16'd0,     7'd0,   32'h1},         1'b1,
          '{32'h0,         12'd0,  ST_OK}},
        '{'{REQ_READ,  16'd0,     16'd0,     7'd0,   32'h0},         1'b1,
          '{32'h7FFF_FFFF, 12'd0,  ST_OK}},
        '{'{REQ_SET,   16'd0,     16'd5,     7'd0,   32'h1},         1'b1,
          '{32'h0,         12'd0,  ST_NOTALLOC}},
        '{'{REQ_READ,  16'd1,     16'd7,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_ABSENT}},
        '{'{REQ_SET,   16'd1,     16'd7,     7'd0,   32'h8000_0000}, 1'b1,
          '{32'h0,         12'd2,  ST_OK}},
        '{'{REQ_ADD,   16'd1,     16'd7,     7'd0,   32'h8000_0000}, 1'b1,
          '{32'h0,         12'd2,  ST_OK}},
        '{'{REQ_READ,  16'd1,     16'd7,     7'd0,   32'h0},         1'b1,
          '{32'h8000_0000, 12'd2,  ST_OK}},
        '{'{REQ_ADD,   16'd2,     16'd1023,  7'd0,   32'h1234_5678}, 1'b0, '0},
        '{'{REQ_ADD,   16'd2,     16'd0,     7'd0,   32'hFFFF_FFFF}, 1'b0, '0},
        '{'{REQ_ADD,   16'd2,     16'd9,     7'd0,   32'h5},         1'b1,
          '{32'h0,         12'd0,  ST_NOTALLOC}},
        '{'{REQ_READ,  16'd2,     16'd0,     7'd0,   32'h0},         1'b0, '0},
        '{'{REQ_READ,  16'd2,     16'hFFFF,  7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd0,  ST_RANGE}},
        '{'{REQ_READ,  16'd3,     16'd3,     7'd0,   32'h0},         1'b1,
          '{32'h0,         12'd68, ST_OK}},
        '{'{REQ_SET,   16'd4,     16'd0,     7'd0,   32'h1},         1'b1,
          '{32'h0,         12'd0,  ST_NOTALLOC}},
        '{'{REQ_ADD,   16'd1,     16'd1,     7'd0,   32'hAAAA_5555}, 1'b0, '0}
    };

    initial
    begin
        entry_req_t it;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part runs on the reset register values
        for (int i = 0; i < DIR_N; i++)
            offer_req(DIR_TAB[i].rq, DIR_TAB[i].typed, DIR_TAB[i].res);
        s_tvalid <= 1'b0;

        write_config(16'd1024, 16'd65535, 1'b1);
        run_phase(260, 8, 40);
        write_config(16'd1024, 16'd1024, 1'b0);
        run_phase(200, 6, -1);
        write_config(16'd1, 16'd1, 1'b1);
        run_phase(100, 8, -1);
        // few rows allowed: setups soon hit the row limit
        write_config(16'(shadow_rows_defined + 2), 16'd300, 1'b1);
        run_phase(150, 30, -1);
        write_config(16'd2047, 16'd65535, 1'b0);
        run_phase(250, 8, -1);
        write_config(16'd1024, 16'd64, 1'b1);
        run_phase(200, 8, -1);
        write_config(16'd1024, 16'd1024, 1'b1);
        run_phase(250, 8, -1);
        // fill the slot storage until setups overflow
        for (int i = 0; i < 70; i++)
        begin
            it     = gen_req(0);
            it.req = REQ_SETUP;
            it.cnt = CNT_W'($urandom_range(64, 127));
            offer_req(it, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
